[hdl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes and ring index arithmetic for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Number of entries in the ring store.
  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = COUNT_W + 1;

  // Payload widths.
  localparam int VALUE_W = 32;
  localparam int ENTRY_W = 7;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 40;

  // Value returned by a pop from an empty queue.
  localparam logic [VALUE_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;

  // Request in flight between the memory access and the output register.
  typedef struct packed {
    logic valid;
    logic use_ram;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0] entry_count;
  } stage_t;

  // (base + off) modulo DEPTH, where base < DEPTH and off <= DEPTH.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [COUNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Entry count as it appears on the output, kept to its low bits.
  function automatic logic [ENTRY_W-1:0] to_entry(input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W+ENTRY_W-1:0] wide;
    wide = {{ENTRY_W{1'b0}}, cnt};
    return wide[ENTRY_W-1:0];
  endfunction

endpackage

[hdl/dq_ram.sv]
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/double_ended_queue.sv]
// Flow: an accepted request waits in the stage register, which is held while the output
// register is full and not drained, then moves into the output register on the master side.
// Throughput: one request per cycle unless the result channel stalls; a request uses the
// store's write or read port at most once, and pointer updates complete in the accept cycle.
// Reset: rst (synchronous, active high) empties the queue and clears both pipeline stages;
// the store itself is not cleared, since only entries written by a push are ever read.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values held in a circular RAM.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [1:0]  s_tuser,   // [1:0] command
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] pop_value, [38:32] entry_count, [39] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  // The front index and entry count describe the ring. The back of the queue is
  // the slot front + count - 1, wrapped modulo the depth.
  logic [dq_pkg::IDX_W-1:0]   front;
  logic [dq_pkg::IDX_W-1:0]   front_next;
  logic [dq_pkg::COUNT_W-1:0] count;
  logic [dq_pkg::COUNT_W-1:0] count_next;

  // Request accepted, RAM access issued, waiting for read data.
  dq_pkg::stage_t stage;
  dq_pkg::stage_t stage_next;

  logic accept;
  logic stage_adv;

  // RAM access signals.
  logic                       ram_we;
  logic                       ram_re;
  logic [dq_pkg::IDX_W-1:0]   ram_waddr;
  logic [dq_pkg::IDX_W-1:0]   ram_raddr;
  logic [dq_pkg::VALUE_W-1:0] ram_rdata;

  logic [dq_pkg::STATUS_W-1:0] status_next;
  logic is_full;
  logic is_empty;

  // The stage moves into the output register whenever that register is empty or
  // is being drained in this cycle. A new request enters whenever the stage is
  // empty or moving on. The RAM read only fires on accept, so its data holds
  // while the stage is stalled.
  assign stage_adv = stage.valid && (!m_tvalid || m_tready);
  assign s_tready  = !stage.valid || stage_adv;
  assign accept    = s_tvalid && s_tready;

  assign is_full  = (count == dq_pkg::COUNT_W'(dq_pkg::DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    front_next  = front;
    count_next  = count;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = dq_pkg::ring_add(front, count);
    ram_raddr   = front;
    status_next = dq_pkg::ST_OK;
    case (s_tuser)
      dq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_next = dq_pkg::ST_OVER;
        end else begin
          // The new front sits one slot below the old one.
          front_next = dq_pkg::ring_add(front, dq_pkg::COUNT_W'(dq_pkg::DEPTH - 1));
          ram_waddr  = front_next;
          ram_we     = accept;
          count_next = count + 1'b1;
        end
      end
      dq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_next = dq_pkg::ST_OVER;
        end else begin
          ram_waddr  = dq_pkg::ring_add(front, count);
          ram_we     = accept;
          count_next = count + 1'b1;
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          status_next = dq_pkg::ST_UNDER;
        end else begin
          ram_raddr  = front;
          ram_re     = accept;
          front_next = dq_pkg::ring_add(front, dq_pkg::COUNT_W'(1));
          count_next = count - 1'b1;
        end
      end
      dq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          status_next = dq_pkg::ST_UNDER;
        end else begin
          ram_raddr  = dq_pkg::ring_add(front, count - 1'b1);
          ram_re     = accept;
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = dq_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    stage_next = stage;
    if (accept) begin
      stage_next.valid       = 1'b1;
      stage_next.use_ram     = ram_re;
      stage_next.status      = status_next;
      stage_next.entry_count = dq_pkg::to_entry(count_next);
    end else if (stage_adv) begin
      stage_next.valid = 1'b0;
    end
  end

  // A push writes the store at the edge that accepts it, so a pop accepted at
  // any later edge already reads the new entry.
  dq_ram #(
    .WIDTH (dq_pkg::VALUE_W),
    .DEPTH (dq_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  // Only the valid bit of the stage needs a reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
    end
    stage.use_ram     <= stage_next.use_ram;
    stage.status      <= stage_next.status;
    stage.entry_count <= stage_next.entry_count;
  end

  // Output register. A pop takes the RAM data, an empty pop returns the largest
  // positive value, and pushes report zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stage_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      m_tuser <= stage.status;
      if (stage.use_ram) begin
        m_tdata <= {1'b0, stage.entry_count, ram_rdata};
      end else if (stage.status == dq_pkg::ST_UNDER) begin
        m_tdata <= {1'b0, stage.entry_count, dq_pkg::INT_MAX};
      end else begin
        m_tdata <= {1'b0, stage.entry_count, {dq_pkg::VALUE_W{1'b0}}};
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dq_pkg::COUNT_W'(dq_pkg::DEPTH))
    else $error("entry count exceeds depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_full &&
     (s_tuser == dq_pkg::CMD_PUSH_FRONT || s_tuser == dq_pkg::CMD_PUSH_BACK))
    |=> (count == $past(count) + 1'b1))
    else $error("accepted push did not grow the queue");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && !stage_adv) |=> (stage.valid && $stable(ram_rdata)))
    else $error("stalled request lost its read data");

  a_under_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == dq_pkg::ST_UNDER) |-> (m_tdata[31:0] == dq_pkg::INT_MAX))
    else $error("underflow result carries wrong value");
`endif

endmodule
